// ----- sv/ihex_pkg.sv -----
`timescale 1ns / 1ps

package ihex_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_ADDR,
        PH_TYPE,
        PH_EXT,
        PH_DATA,
        PH_CKSUM,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_ACCEPT,
        KIND_REJECT,
        KIND_EOF
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NO_COLON,
        ERR_BAD_DIGIT,
        ERR_BAD_TYPE,
        ERR_TOO_LONG,
        ERR_CHECKSUM,
        ERR_SHORT_LINE
    } err_t;

    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXT_SEG = 8'h02;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    localparam logic [7:0] MAX_LEN_RESET = 8'd64;

    localparam logic [7:0] REG_MAX_LEN_ADDR = 8'h00;

    // bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CHAR_NUL) || (c == CHAR_LF) || (c == CHAR_CR);
    endfunction

endpackage

// ----- sv/ihex_cfg.sv -----
`timescale 1ns / 1ps

module ihex_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  max_record_len
);

    logic [7:0] max_len_reg;
    logic [7:0] max_len_next;
    logic       addr_hit;

    assign pready   = 1'b1;
    assign addr_hit = ({6'b0, paddr} == ihex_pkg::REG_MAX_LEN_ADDR);

    always_comb
    begin
        max_len_next = max_len_reg;
        if (psel && penable && pwrite && addr_hit) begin
            max_len_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg <= ihex_pkg::MAX_LEN_RESET;
        end
        else begin
            max_len_reg <= max_len_next;
        end
    end

    assign prdata         = addr_hit ? {24'b0, max_len_reg} : 32'b0;
    assign max_record_len = max_len_reg;

endmodule

// ----- sv/intel_hex_record_parser_core.sv -----
`timescale 1ns / 1ps

// intel hex record parser, one ascii character per input word
// input channel: in_valid / in_stall / in_char; a word is taken at a clock
//   edge with in_valid high and in_stall low
// output channel: out_valid / out_stall and the result fields; each input
//   word gives zero or one result word (data byte, record accepted, record
//   rejected, end of file)
// a result appears on the output in the cycle after its character is taken;
//   one character is taken every cycle while the output flows
// the character decode, the 8-bit running sum and the 32-bit address add sit
//   between the parser state and the output register
// a held result is kept while out_stall is high; in_stall follows it, so no
//   character is taken until the held word leaves (the same cycle it leaves)
// after end of file every character is taken and dropped
// reset clears the parser to wait for a line start, the extended base to zero
//   and max_record_len (apb address 0) to 64; write it only while idle

module intel_hex_record_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] address,
    output logic [7:0]  data_byte,
    output logic [7:0]  record_type,
    output logic [2:0]  error_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] max_len;

    ihex_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .max_record_len (max_len)
    );

    ihex_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  nib_reg, nib_next;
    logic [15:0] field_reg, field_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  index_reg, index_next;
    logic [31:0] base_reg, base_next;
    logic        eof_reg, eof_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  byte_reg, byte_next;
    logic [7:0]  rtype_reg, rtype_next;
    logic [2:0]  err_reg, err_next;

    logic        take;
    logic        eol;
    logic [4:0]  dig;
    logic [15:0] fv;
    logic [2:0]  cnt;
    logic        is_word;
    logic        field_done;
    logic [7:0]  sum_add;
    logic [7:0]  tc;
    logic [7:0]  index_inc;
    logic [31:0] data_addr;

    assign in_stall   = out_valid_reg && out_stall;
    assign take       = in_valid && !in_stall && !eof_reg;
    assign eol        = ihex_pkg::is_eol(in_char);
    assign dig        = ihex_pkg::hex_digit(in_char);
    assign fv         = {field_reg[11:0], dig[3:0]};
    assign cnt        = {1'b0, nib_reg} + 3'd1;
    assign is_word    = (phase_reg == ihex_pkg::PH_ADDR) || (phase_reg == ihex_pkg::PH_EXT);
    assign field_done = is_word ? (cnt == 3'd4) : (cnt == 3'd2);
    assign sum_add    = cnt[0] ? sum_reg : sum_reg + fv[7:0];
    assign tc         = fv[7:0];
    assign index_inc  = index_reg + 8'd1;
    assign data_addr  = base_reg + {16'b0, offset_reg} + {24'b0, index_reg};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take) begin
            case (phase_reg)
                ihex_pkg::PH_IDLE:
                begin
                    if (!eol) begin
                        phase_next = (in_char == ihex_pkg::CHAR_COLON) ?
                                     ihex_pkg::PH_LEN : ihex_pkg::PH_SKIP;
                    end
                end
                ihex_pkg::PH_SKIP:
                begin
                    if (eol) begin
                        phase_next = ihex_pkg::PH_IDLE;
                    end
                end
                ihex_pkg::PH_LEN, ihex_pkg::PH_ADDR, ihex_pkg::PH_TYPE,
                ihex_pkg::PH_EXT, ihex_pkg::PH_DATA, ihex_pkg::PH_CKSUM:
                begin
                    if (eol) begin
                        phase_next = ihex_pkg::PH_IDLE;
                    end
                    else if (!dig[4]) begin
                        phase_next = ihex_pkg::PH_SKIP;
                    end
                    else if (field_done) begin
                        case (phase_reg)
                            ihex_pkg::PH_LEN:  phase_next = ihex_pkg::PH_ADDR;
                            ihex_pkg::PH_ADDR: phase_next = ihex_pkg::PH_TYPE;
                            ihex_pkg::PH_TYPE:
                            begin
                                if (tc == ihex_pkg::REC_EOF) begin
                                    phase_next = ihex_pkg::PH_IDLE;
                                end
                                else if (tc == ihex_pkg::REC_EXT_SEG ||
                                         tc == ihex_pkg::REC_EXT_LIN) begin
                                    phase_next = (len_reg == 8'd2) ?
                                                 ihex_pkg::PH_EXT : ihex_pkg::PH_SKIP;
                                end
                                else if (tc != ihex_pkg::REC_DATA ||
                                         len_reg > max_len) begin
                                    phase_next = ihex_pkg::PH_SKIP;
                                end
                                else begin
                                    phase_next = (len_reg == 8'd0) ?
                                                 ihex_pkg::PH_CKSUM : ihex_pkg::PH_DATA;
                                end
                            end
                            ihex_pkg::PH_EXT:  phase_next = ihex_pkg::PH_CKSUM;
                            ihex_pkg::PH_DATA:
                            begin
                                phase_next = (index_inc >= len_reg) ?
                                             ihex_pkg::PH_CKSUM : ihex_pkg::PH_DATA;
                            end
                            default:           phase_next = ihex_pkg::PH_SKIP;
                        endcase
                    end
                end
                default:
                begin
                    phase_next = ihex_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        nib_next    = nib_reg;
        field_next  = field_reg;
        len_next    = len_reg;
        offset_next = offset_reg;
        type_next   = type_reg;
        sum_next    = sum_reg;
        index_next  = index_reg;
        base_next   = base_reg;
        eof_next    = eof_reg;

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        byte_next      = byte_reg;
        rtype_next     = rtype_reg;
        err_next       = err_reg;

        if (take) begin
            kind_next = ihex_pkg::KIND_REJECT;
            addr_next = 32'b0;
            byte_next = 8'b0;
            err_next  = ihex_pkg::ERR_NONE;
            case (phase_reg)
                ihex_pkg::PH_IDLE:
                begin
                    if (!eol) begin
                        type_next = 8'b0;
                        if (in_char != ihex_pkg::CHAR_COLON) begin
                            out_valid_next = 1'b1;
                            err_next       = ihex_pkg::ERR_NO_COLON;
                        end
                        else begin
                            sum_next   = 8'b0;
                            index_next = 8'b0;
                            nib_next   = 2'b0;
                            field_next = 16'b0;
                        end
                    end
                end
                ihex_pkg::PH_SKIP:
                begin
                end
                ihex_pkg::PH_LEN, ihex_pkg::PH_ADDR, ihex_pkg::PH_TYPE,
                ihex_pkg::PH_EXT, ihex_pkg::PH_DATA, ihex_pkg::PH_CKSUM:
                begin
                    if (eol) begin
                        out_valid_next = 1'b1;
                        err_next       = ihex_pkg::ERR_SHORT_LINE;
                    end
                    else if (!dig[4]) begin
                        out_valid_next = 1'b1;
                        err_next       = ihex_pkg::ERR_BAD_DIGIT;
                    end
                    else begin
                        field_next = fv;
                        nib_next   = cnt[1:0];
                        sum_next   = sum_add;
                        if (field_done) begin
                            nib_next   = 2'b0;
                            field_next = 16'b0;
                            case (phase_reg)
                                ihex_pkg::PH_LEN:  len_next = fv[7:0];
                                ihex_pkg::PH_ADDR: offset_next = fv;
                                ihex_pkg::PH_TYPE:
                                begin
                                    type_next = tc;
                                    if (tc == ihex_pkg::REC_EOF) begin
                                        eof_next       = 1'b1;
                                        out_valid_next = 1'b1;
                                        kind_next      = ihex_pkg::KIND_EOF;
                                    end
                                    else if (tc == ihex_pkg::REC_EXT_SEG ||
                                             tc == ihex_pkg::REC_EXT_LIN) begin
                                        if (len_reg != 8'd2) begin
                                            out_valid_next = 1'b1;
                                            err_next       = ihex_pkg::ERR_BAD_TYPE;
                                        end
                                    end
                                    else if (tc != ihex_pkg::REC_DATA) begin
                                        out_valid_next = 1'b1;
                                        err_next       = ihex_pkg::ERR_BAD_TYPE;
                                    end
                                    else if (len_reg > max_len) begin
                                        out_valid_next = 1'b1;
                                        err_next       = ihex_pkg::ERR_TOO_LONG;
                                    end
                                end
                                ihex_pkg::PH_EXT:  offset_next = fv;
                                ihex_pkg::PH_DATA:
                                begin
                                    index_next     = index_inc;
                                    out_valid_next = 1'b1;
                                    kind_next      = ihex_pkg::KIND_DATA;
                                    addr_next      = data_addr;
                                    byte_next      = fv[7:0];
                                end
                                ihex_pkg::PH_CKSUM:
                                begin
                                    out_valid_next = 1'b1;
                                    if (sum_add != 8'd0) begin
                                        err_next = ihex_pkg::ERR_CHECKSUM;
                                    end
                                    else begin
                                        kind_next = ihex_pkg::KIND_ACCEPT;
                                        if (type_reg == ihex_pkg::REC_EXT_SEG) begin
                                            base_next = {12'b0, offset_reg, 4'b0};
                                        end
                                        else if (type_reg == ihex_pkg::REC_EXT_LIN) begin
                                            base_next = {offset_reg, 16'b0};
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                end
            endcase
            rtype_next = type_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= ihex_pkg::PH_IDLE;
            nib_reg       <= 2'b0;
            field_reg     <= 16'b0;
            len_reg       <= 8'b0;
            offset_reg    <= 16'b0;
            type_reg      <= 8'b0;
            sum_reg       <= 8'b0;
            index_reg     <= 8'b0;
            base_reg      <= 32'b0;
            eof_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            phase_reg     <= phase_next;
            nib_reg       <= nib_next;
            field_reg     <= field_next;
            len_reg       <= len_next;
            offset_reg    <= offset_next;
            type_reg      <= type_next;
            sum_reg       <= sum_next;
            index_reg     <= index_next;
            base_reg      <= base_next;
            eof_reg       <= eof_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        addr_reg  <= addr_next;
        byte_reg  <= byte_next;
        rtype_reg <= rtype_next;
        err_reg   <= err_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign address     = addr_reg;
    assign data_byte   = byte_reg;
    assign record_type = rtype_reg;
    assign error_code  = err_reg;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        ihex_pkg::kind_t kind;
        logic [31:0]     addr;
        logic [7:0]      value;
        logic [7:0]      rtype;
        ihex_pkg::err_t  err;
    } hex_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_char = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  record_type;
    logic [2:0]  error_code;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'b00;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    intel_hex_record_parser_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_char     (in_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .address     (address),
        .data_byte   (data_byte),
        .record_type (record_type),
        .error_code  (error_code),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // parser state mirrored by the testbench
    ihex_pkg::phase_t line_phase = ihex_pkg::PH_IDLE;
    logic [1:0]  nib_cnt = 2'd0;
    logic [15:0] field_acc = 16'h0;
    logic [7:0]  rec_len = 8'h0;
    logic [15:0] rec_offset = 16'h0;
    logic [7:0]  rec_type = 8'h0;
    logic [7:0]  chk_sum = 8'h0;
    logic [7:0]  byte_idx = 8'h0;
    logic [31:0] seg_base = 32'h0;
    logic        file_ended = 1'b0;
    logic [7:0]  max_len = ihex_pkg::MAX_LEN_RESET;

    hex_result_t results_due[$];
    logic [7:0]  text_queue[$];
    logic [7:0]  line_buf[$];
    logic [7:0]  payload[$];
    logic [7:0]  sum_skew = 8'h0;
    int          queued = 0;
    int          mismatches = 0;
    logic        char_taken = 1'b0;
    logic        no_idle = 1'b0;
    logic        out_hold = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (c >= "0" && c <= "9")
        begin
            return {1'b1, c[3:0]};
        end
        if (lc >= "a" && lc <= "f")
        begin
            return {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return 5'h00;
    endfunction

    function automatic logic is_line_end(input logic [7:0] c);
        return (c == ihex_pkg::CHAR_NUL) || (c == ihex_pkg::CHAR_LF) ||
               (c == ihex_pkg::CHAR_CR);
    endfunction

    function automatic void post(input ihex_pkg::kind_t k, input logic [31:0] a,
                                 input logic [7:0] v, input ihex_pkg::err_t e);
        hex_result_t r;
        r.kind = k;
        r.addr = a;
        r.value = v;
        r.rtype = rec_type;
        r.err = e;
        results_due.push_back(r);
    endfunction

    function automatic void refuse(input ihex_pkg::err_t e, input ihex_pkg::phase_t nxt);
        line_phase = nxt;
        post(ihex_pkg::KIND_REJECT, 32'h0, 8'h0, e);
    endfunction

    function automatic void open_field(input ihex_pkg::phase_t nxt);
        line_phase = nxt;
        nib_cnt = 2'd0;
        field_acc = 16'h0;
    endfunction

    task automatic parse_char(input logic [7:0] c);
        logic [4:0] dig;
        logic [2:0] n;
        logic       eol;
        eol = is_line_end(c);
        dig = nibble_of(c);
        if (file_ended)
        begin
            return;
        end
        if (line_phase == ihex_pkg::PH_IDLE)
        begin
            if (eol)
            begin
                return;
            end
            rec_type = 8'h00;
            if (c != ihex_pkg::CHAR_COLON)
            begin
                refuse(ihex_pkg::ERR_NO_COLON, ihex_pkg::PH_SKIP);
            end
            else
            begin
                chk_sum = 8'h0;
                byte_idx = 8'h0;
                open_field(ihex_pkg::PH_LEN);
            end
            return;
        end
        if (line_phase == ihex_pkg::PH_SKIP)
        begin
            if (eol)
            begin
                line_phase = ihex_pkg::PH_IDLE;
            end
            return;
        end
        if (eol)
        begin
            refuse(ihex_pkg::ERR_SHORT_LINE, ihex_pkg::PH_IDLE);
            return;
        end
        if (!dig[4])
        begin
            refuse(ihex_pkg::ERR_BAD_DIGIT, ihex_pkg::PH_SKIP);
            return;
        end
        field_acc = {field_acc[11:0], dig[3:0]};
        n = {1'b0, nib_cnt} + 3'd1;
        nib_cnt = n[1:0];
        if (!n[0])
        begin
            chk_sum = chk_sum + field_acc[7:0];
        end
        if (n != ((line_phase == ihex_pkg::PH_ADDR || line_phase == ihex_pkg::PH_EXT) ?
                  3'd4 : 3'd2))
        begin
            return;
        end
        case (line_phase)
            ihex_pkg::PH_LEN:
            begin
                rec_len = field_acc[7:0];
                open_field(ihex_pkg::PH_ADDR);
            end
            ihex_pkg::PH_ADDR:
            begin
                rec_offset = field_acc;
                open_field(ihex_pkg::PH_TYPE);
            end
            ihex_pkg::PH_TYPE:
            begin
                rec_type = field_acc[7:0];
                if (rec_type == ihex_pkg::REC_EOF)
                begin
                    file_ended = 1'b1;
                    line_phase = ihex_pkg::PH_IDLE;
                    post(ihex_pkg::KIND_EOF, 32'h0, 8'h0, ihex_pkg::ERR_NONE);
                end
                else if (rec_type == ihex_pkg::REC_EXT_SEG ||
                         rec_type == ihex_pkg::REC_EXT_LIN)
                begin
                    if (rec_len != 8'd2)
                    begin
                        refuse(ihex_pkg::ERR_BAD_TYPE, ihex_pkg::PH_SKIP);
                    end
                    else
                    begin
                        open_field(ihex_pkg::PH_EXT);
                    end
                end
                else if (rec_type != ihex_pkg::REC_DATA)
                begin
                    refuse(ihex_pkg::ERR_BAD_TYPE, ihex_pkg::PH_SKIP);
                end
                else if (rec_len > max_len)
                begin
                    refuse(ihex_pkg::ERR_TOO_LONG, ihex_pkg::PH_SKIP);
                end
                else if (rec_len == 8'd0)
                begin
                    open_field(ihex_pkg::PH_CKSUM);
                end
                else
                begin
                    open_field(ihex_pkg::PH_DATA);
                end
            end
            ihex_pkg::PH_EXT:
            begin
                // base value parked in the offset until the checksum passes
                rec_offset = field_acc;
                open_field(ihex_pkg::PH_CKSUM);
            end
            ihex_pkg::PH_DATA:
            begin
                post(ihex_pkg::KIND_DATA, seg_base + 32'(rec_offset) + 32'(byte_idx),
                     field_acc[7:0], ihex_pkg::ERR_NONE);
                byte_idx = byte_idx + 8'd1;
                if (byte_idx >= rec_len)
                begin
                    open_field(ihex_pkg::PH_CKSUM);
                end
                else
                begin
                    open_field(ihex_pkg::PH_DATA);
                end
            end
            ihex_pkg::PH_CKSUM:
            begin
                if (chk_sum != 8'h0)
                begin
                    refuse(ihex_pkg::ERR_CHECKSUM, ihex_pkg::PH_SKIP);
                end
                else
                begin
                    if (rec_type == ihex_pkg::REC_EXT_SEG)
                    begin
                        seg_base = {12'h0, rec_offset, 4'h0};
                    end
                    else if (rec_type == ihex_pkg::REC_EXT_LIN)
                    begin
                        seg_base = {rec_offset, 16'h0};
                    end
                    line_phase = ihex_pkg::PH_SKIP;
                    post(ihex_pkg::KIND_ACCEPT, 32'h0, 8'h0, ihex_pkg::ERR_NONE);
                end
            end
            default:
            begin
                line_phase = ihex_pkg::PH_IDLE;
            end
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch: %0s got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // result check and character prediction
    always @(posedge clk)
    begin : watch
        hex_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    report("unexpected word, kind", result_kind, 0);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (result_kind !== want.kind)
                        report("result_kind", result_kind, want.kind);
                    if (address !== want.addr)
                        report("address", address, want.addr);
                    if (data_byte !== want.value)
                        report("data_byte", data_byte, want.value);
                    if (record_type !== want.rtype)
                        report("record_type", record_type, want.rtype);
                    if (error_code !== want.err)
                        report("error_code", error_code, want.err);
                end
            end
            if (in_valid && !in_stall)
            begin
                parse_char(in_char);
            end
        end
        char_taken = rst_n && in_valid && !in_stall;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || char_taken)
        begin
            if (text_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 7))
            begin
                in_valid <= 1'b1;
                in_char <= text_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= out_hold || (!no_idle && $urandom_range(0, 99) < 7);
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return "0" + 8'(nib);
        end
        return ($urandom_range(0, 1) ? "A" : "a") + 8'(nib - 4'd10);
    endfunction

    function automatic void put_hex(input logic [7:0] b);
        line_buf.push_back(hex_char(b[7:4]));
        line_buf.push_back(hex_char(b[3:0]));
    endfunction

    function automatic void put_char(input logic [7:0] c);
        text_queue.push_back(c);
        queued++;
    endfunction

    function automatic void end_line();
        foreach (line_buf[k])
        begin
            put_char(line_buf[k]);
        end
        line_buf.delete();
        case ($urandom_range(0, 3))
            0: put_char(ihex_pkg::CHAR_CR);
            1: put_char(ihex_pkg::CHAR_LF);
            2:
            begin
                put_char(ihex_pkg::CHAR_CR);
                put_char(ihex_pkg::CHAR_LF);
            end
            default: put_char(ihex_pkg::CHAR_NUL);
        endcase
    endfunction

    // colon, header, payload and checksum into line_buf
    function automatic void make_record(input logic [7:0] typ, input logic [7:0] len,
                                        input logic [15:0] off);
        logic [7:0] s;
        logic [7:0] ck;
        line_buf.delete();
        line_buf.push_back(ihex_pkg::CHAR_COLON);
        s = len + off[15:8] + off[7:0] + typ;
        put_hex(len);
        put_hex(off[15:8]);
        put_hex(off[7:0]);
        put_hex(typ);
        foreach (payload[k])
        begin
            put_hex(payload[k]);
            s = s + payload[k];
        end
        ck = 8'h0 - s + sum_skew;
        put_hex(ck);
        sum_skew = 8'h0;
        payload.delete();
    endfunction

    function automatic void random_payload(input int count);
        payload.delete();
        for (int k = 0; k < count; k++)
        begin
            payload.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic logic [7:0] odd_char(input logic allow_hex, input logic allow_colon);
        logic [7:0] c;
        logic [4:0] nib;
        do
        begin
            c = 8'($urandom_range(0, 255));
            nib = nibble_of(c);
        end
        while (is_line_end(c) || (!allow_hex && nib[4])
               || (!allow_colon && c == ihex_pkg::CHAR_COLON));
        return c;
    endfunction

    function automatic logic [7:0] pick_len(input logic [7:0] limit);
        if (limit == 8'd0)
        begin
            return 8'd0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            return 8'($urandom_range(0, limit));
        end
        return 8'($urandom_range(0, (limit < 8'd12) ? limit : 12));
    endfunction

    function automatic void random_line(input logic [7:0] limit);
        int         pick;
        int         pos;
        logic [7:0] len;
        logic [7:0] typ;
        pick = $urandom_range(0, 99);
        len = pick_len(limit);
        if (pick < 50)
        begin
            random_payload(len);
            make_record(ihex_pkg::REC_DATA, len, 16'($urandom));
        end
        else if (pick < 58)
        begin
            random_payload(2);
            if ($urandom_range(0, 4) == 0)
            begin
                payload[0] = 8'hff;
                payload[1] = 8'hff;
            end
            make_record((pick < 54) ? ihex_pkg::REC_EXT_SEG : ihex_pkg::REC_EXT_LIN, 8'd2,
                        16'($urandom));
        end
        else if (pick < 62 && limit != 8'd255)
        begin
            // byte count over the limit, rejected at the type field
            random_payload(2);
            make_record(ihex_pkg::REC_DATA, 8'($urandom_range(limit + 1, 255)),
                        16'($urandom));
        end
        else if (pick < 66)
        begin
            random_payload(len);
            sum_skew = 8'($urandom_range(1, 255));
            make_record(ihex_pkg::REC_DATA, len, 16'($urandom));
        end
        else if (pick < 70)
        begin
            random_payload(len);
            make_record(ihex_pkg::REC_DATA, len, 16'($urandom));
            pos = $urandom_range(1, line_buf.size() - 1);
            line_buf[pos] = odd_char(1'b0, 1'b1);
        end
        else if (pick < 74)
        begin
            // line ends inside the record
            random_payload(len);
            make_record(($urandom_range(0, 3) == 0) ? ihex_pkg::REC_EXT_LIN : ihex_pkg::REC_DATA,
                        ($urandom_range(0, 3) == 0) ? 8'd2 : len, 16'($urandom));
            pos = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > pos)
            begin
                void'(line_buf.pop_back());
            end
        end
        else if (pick < 77)
        begin
            line_buf.push_back(odd_char(1'b1, 1'b0));
            for (int k = $urandom_range(0, 8); k > 0; k--)
            begin
                line_buf.push_back(hex_char(4'($urandom)));
            end
        end
        else if (pick < 80)
        begin
            if ($urandom_range(0, 1))
            begin
                do
                begin
                    typ = 8'($urandom_range(0, 255));
                end
                while (typ == ihex_pkg::REC_DATA || typ == ihex_pkg::REC_EOF
                       || typ == ihex_pkg::REC_EXT_SEG || typ == ihex_pkg::REC_EXT_LIN);
                random_payload(1);
                make_record(typ, 8'($urandom_range(0, 255)), 16'($urandom));
            end
            else
            begin
                do
                begin
                    len = 8'($urandom_range(0, 255));
                end
                while (len == 8'd2);
                random_payload(1);
                make_record($urandom_range(0, 1) ? ihex_pkg::REC_EXT_SEG : ihex_pkg::REC_EXT_LIN,
                            len, 16'($urandom));
            end
        end
        else if (pick < 84)
        begin
            line_buf.delete();
        end
        else if (pick < 88)
        begin
            line_buf.push_back(odd_char(1'b1, 1'b0));
            for (int k = $urandom_range(0, 10); k > 0; k--)
            begin
                line_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            // trailing characters after the checksum are ignored
            random_payload(len);
            make_record(ihex_pkg::REC_DATA, len, 16'($urandom));
            for (int k = $urandom_range(1, 6); k > 0; k--)
            begin
                line_buf.push_back(odd_char(1'b1, 1'b1));
            end
        end
        end_line();
    endfunction

    function automatic void fill_text(input int budget);
        int stop_at;
        stop_at = queued + budget;
        while (queued < stop_at)
        begin
            random_line(max_len);
        end
    endfunction

    task automatic wait_quiet();
        @(posedge clk);
        while (text_queue.size() != 0 || in_valid || results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [7:0] v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ihex_pkg::REG_MAX_LEN_ADDR[1:0];
        pwdata = {24'h0, v};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        max_len = v;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes: linear base ffff, byte ff at offset ffff, bare colon, 8'hff line
        payload.push_back(8'hff);
        payload.push_back(8'hff);
        make_record(ihex_pkg::REC_EXT_LIN, 8'd2, 16'h0000);
        end_line();
        payload.push_back(8'hff);
        make_record(ihex_pkg::REC_DATA, 8'd1, 16'hffff);
        end_line();
        line_buf.push_back(ihex_pkg::CHAR_COLON);
        end_line();
        line_buf.push_back(8'hff);
        end_line();
        fill_text(60);
        wait_quiet();

        write_max_len(8'd0);
        make_record(ihex_pkg::REC_DATA, 8'd0, 16'h0000);
        end_line();
        random_payload(1);
        make_record(ihex_pkg::REC_DATA, 8'd1, 16'h1234);
        end_line();
        fill_text(60);
        wait_quiet();

        write_max_len(8'd255);
        random_payload(255);
        make_record(ihex_pkg::REC_DATA, 8'd255, 16'($urandom));
        end_line();
        fill_text(30);
        wait_quiet();

        // no idling on either side
        write_max_len(8'($urandom_range(1, 254)));
        no_idle = 1'b1;
        fill_text(130);
        wait_quiet();
        no_idle = 1'b0;

        // long receiver hold while characters keep coming
        write_max_len(8'd1);
        fill_text(130);
        fork
            begin
                out_hold = 1'b1;
                repeat (150) @(posedge clk);
                out_hold = 1'b0;
            end
        join_none
        wait_quiet();

        write_max_len(8'($urandom_range(16, 80)));
        fill_text(130);
        wait_quiet();

        write_max_len(ihex_pkg::MAX_LEN_RESET);
        fill_text(50);
        random_payload($urandom_range(0, 3));
        make_record(ihex_pkg::REC_EOF, 8'(payload.size()), 16'($urandom));
        end_line();
        for (int k = 0; k < 12; k++)
        begin
            put_char(8'($urandom_range(0, 255)));
        end
        wait_quiet();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
